[sv/shapad_pkg.sv]
// ----------------------------------------------------------------------------
// shapad_pkg
// Shared constants and controller/datapath interface types of the
// SHA-512 message padder.
// ----------------------------------------------------------------------------
package shapad_pkg;

    localparam int WORD_BITS            = 64;
    localparam int WORD_NIBS            = WORD_BITS / 4;
    localparam int POS_W                = $clog2(WORD_NIBS);
    localparam int DEF_BLOCK_BITS       = 1024;
    localparam int DEF_LENGTH_OFF_BITS  = 896;
    localparam logic [3:0] PAD_MARK     = 4'h8;

    // valid_nibbles codes
    localparam logic [1:0] VN_NONE = 2'd0;
    localparam logic [1:0] VN_HIGH = 2'd1;

    // commands from the controller, at most one per cycle
    typedef struct packed {
        logic accept;     // take the input item
        logic emit_mark;  // close the open word with the one bit
        logic emit_zero;  // zero fill word
        logic emit_len;   // next word of the length field
    } cmd_t;

    // status from the datapath
    typedef struct packed {
        logic out_free;     // output register can be loaded this cycle
        logic offset_next;  // word after the current one starts the length field
        logic len_last;     // current length word is the final one
    } sts_t;

endpackage

[sv/shapad_ctrl.sv]
// ----------------------------------------------------------------------------
// shapad_ctrl
// Sequencer: message phase, then one-bit word, zero fill words and length
// words of the padding.
// ----------------------------------------------------------------------------
module shapad_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  shapad_pkg::sts_t  sts,
    output shapad_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_MSG,
        ST_MARK,
        ST_ZERO,
        ST_LEN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_MSG) && sts.out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_MSG: begin
                if (s_tvalid && s_tready) begin
                    cmd.accept = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK, ST_ZERO: begin
                if (sts.out_free) begin
                    cmd.emit_mark = (state_reg == ST_MARK);
                    cmd.emit_zero = (state_reg == ST_ZERO);
                    state_next    = sts.offset_next ? ST_LEN : ST_ZERO;
                end
            end
            ST_LEN: begin
                if (sts.out_free) begin
                    cmd.emit_len = 1'b1;
                    if (sts.len_last) begin
                        state_next = ST_MSG;
                    end
                end
            end
            default: begin
                state_next = ST_MSG;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_MSG;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/shapad_dp.sv]
// ----------------------------------------------------------------------------
// shapad_dp
// Word assembly, block position, nibble counter, length words and the
// output register.
// ----------------------------------------------------------------------------
module shapad_dp #(
    parameter int BLOCK_BITS         = shapad_pkg::DEF_BLOCK_BITS,
    parameter int LENGTH_OFFSET_BITS = shapad_pkg::DEF_LENGTH_OFF_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [15:0]                        s_tdata,
    input  shapad_pkg::cmd_t                   cmd,
    output shapad_pkg::sts_t                   sts,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [shapad_pkg::WORD_BITS-1:0]   m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int WB           = shapad_pkg::WORD_BITS;
    localparam int PW           = shapad_pkg::POS_W;
    localparam int BLOCK_WORDS  = BLOCK_BITS / WB;
    localparam int OFFSET_WORDS = LENGTH_OFFSET_BITS / WB;
    localparam int LEN_WORDS    = BLOCK_WORDS - OFFSET_WORDS;
    localparam int IDX_W        = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int LCNT_W       = (LEN_WORDS > 1) ? $clog2(LEN_WORDS) : 1;

    logic [WB-1:0]     partial_word_reg;
    logic [WB-1:0]     partial_word_next;
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_inc;
    logic [63:0]       count_reg;
    logic [63:0]       count_next;
    logic [LCNT_W-1:0] len_cnt_reg;
    logic              valid_reg;
    logic [WB-1:0]     word_reg;
    logic              blk_reg;
    logic              last_reg;

    logic [7:0]        data_byte;
    logic [1:0]        valid_nibbles;
    logic              take_hi;
    logic              take_lo;
    logic [PW:0]       pos_t;
    logic              msg_emit;
    logic [WB-1:0]     msg_word;
    logic [PW+2:0]     pw_shift;
    logic [PW+1:0]     mark_shift;
    logic [WB-1:0]     mark_word;
    logic [WB-1:0]     len_word;
    logic              at_block_end;
    logic              load;
    logic [WB-1:0]     load_word;

    assign data_byte     = s_tdata[7:0];
    assign valid_nibbles = s_tdata[9:8];
    assign take_hi       = (valid_nibbles != shapad_pkg::VN_NONE);
    assign take_lo       = take_hi && (valid_nibbles != shapad_pkg::VN_HIGH);

    // pack up to two nibbles, a full word leaves at most once per item
    always_comb begin
        partial_word_next = partial_word_reg;
        pos_t             = {1'b0, pos_reg};
        msg_emit          = 1'b0;
        msg_word          = '0;
        if (take_hi) begin
            partial_word_next = {partial_word_next[WB-5:0], data_byte[7:4]};
            pos_t             = pos_t + 1'b1;
            if (pos_t[PW]) begin
                msg_emit          = 1'b1;
                msg_word          = partial_word_next;
                partial_word_next = '0;
                pos_t             = '0;
            end
        end
        if (take_lo) begin
            partial_word_next = {partial_word_next[WB-5:0], data_byte[3:0]};
            pos_t             = pos_t + 1'b1;
            if (pos_t[PW]) begin
                msg_emit          = 1'b1;
                msg_word          = partial_word_next;
                partial_word_next = '0;
                pos_t             = '0;
            end
        end
        pos_next   = pos_t[PW-1:0];
        count_next = count_reg + {62'd0, take_lo, take_hi ^ take_lo};
    end

    // open word left-aligned, one bit right after it
    assign pw_shift   = {(PW+1)'(shapad_pkg::WORD_NIBS) - {1'b0, pos_reg}, 2'b00};
    assign mark_shift = {(PW)'(shapad_pkg::WORD_NIBS - 1) - pos_reg, 2'b00};
    assign mark_word  = (partial_word_reg << pw_shift)
                      | ({{(WB-4){1'b0}}, shapad_pkg::PAD_MARK} << mark_shift);

    // bit length is 4 * nibble count, 66 bits at the bottom of the field
    always_comb begin
        if (len_cnt_reg == '0) begin
            len_word = {count_reg[61:0], 2'b00};
        end else if (len_cnt_reg == LCNT_W'(1)) begin
            len_word = {{(WB-2){1'b0}}, count_reg[63:62]};
        end else begin
            len_word = '0;
        end
    end

    assign at_block_end = (idx_reg == IDX_W'(BLOCK_WORDS - 1));
    assign idx_inc      = at_block_end ? '0 : idx_reg + 1'b1;

    assign sts.out_free    = !valid_reg || m_tready;
    assign sts.offset_next = (idx_inc == IDX_W'(OFFSET_WORDS));
    assign sts.len_last    = (len_cnt_reg == '0);

    assign load = (cmd.accept && msg_emit) || cmd.emit_mark || cmd.emit_zero
               || cmd.emit_len;

    always_comb begin
        if (cmd.emit_mark) begin
            load_word = mark_word;
        end else if (cmd.emit_len) begin
            load_word = len_word;
        end else if (cmd.accept) begin
            load_word = msg_word;
        end else begin
            load_word = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_word_reg <= '0;
            pos_reg          <= '0;
            idx_reg          <= '0;
            count_reg        <= '0;
            len_cnt_reg      <= LCNT_W'(LEN_WORDS - 1);
            valid_reg        <= 1'b0;
        end else begin
            if (cmd.accept) begin
                partial_word_reg <= partial_word_next;
                pos_reg          <= pos_next;
                count_reg        <= count_next;
            end
            if (cmd.emit_mark) begin
                partial_word_reg <= '0;
                pos_reg          <= '0;
            end
            if (cmd.emit_len) begin
                if (sts.len_last) begin
                    len_cnt_reg <= LCNT_W'(LEN_WORDS - 1);
                    count_reg   <= '0;
                end else begin
                    len_cnt_reg <= len_cnt_reg - 1'b1;
                end
            end
            if (load) begin
                idx_reg   <= idx_inc;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
            blk_reg  <= at_block_end;
            last_reg <= cmd.emit_len && sts.len_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = blk_reg;
    assign m_tlast  = last_reg;

endmodule

[sv/sha512_message_padder_top.sv]
// A word completed by an input item is registered and appears on m_* in the cycle after the transfer.
// Throughput: one input item per cycle while the output side keeps up.
// After the last item the sequencer sends the padding words: the one-bit word, zero
// words and the length words (3 to 18 words); the input waits for that sequencer.
// Reset (aresetn low, synchronous) reinitialises the counters, clears the open word and the output
// valid; the block is then ready for a new message.
// ----------------------------------------------------------------------------
// sha512_message_padder_top
// SHA-512 message padding: packs message nibbles into 64-bit words and appends
// the one bit, zero fill and the 128-bit message length.
// ----------------------------------------------------------------------------
module sha512_message_padder_top #(
    parameter int BLOCK_BITS         = shapad_pkg::DEF_BLOCK_BITS,
    parameter int LENGTH_OFFSET_BITS = shapad_pkg::DEF_LENGTH_OFF_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // data_byte[7:0], valid_nibbles[9:8]
    input  logic                             s_tlast,   // is_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [shapad_pkg::WORD_BITS-1:0] m_tdata,   // word[63:0]
    output logic                             m_tuser,   // block_end
    output logic                             m_tlast    // message_end
);

    shapad_pkg::cmd_t cmd;
    shapad_pkg::sts_t sts;

    shapad_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    shapad_dp #(
        .BLOCK_BITS         (BLOCK_BITS),
        .LENGTH_OFFSET_BITS (LENGTH_OFFSET_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // the length field always closes a block
    a_end_on_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("message end word not at block end");

    // controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.emit_mark, cmd.emit_zero, cmd.emit_len}))
        else $error("more than one datapath command");

    // after the final length word the input side opens again
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_len && sts.len_last |=> s_tready == (!m_tvalid || m_tready))
        else $error("input not reopened after message end");
`endif

endmodule

[verif/sha512_message_padder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_message_padder_top_test
// Streams random and hand-picked messages into the padder under random
// valid/ready gaps and checks every output word against a nibble-level model.
// ----------------------------------------------------------------------------
module sha512_message_padder_top_test;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET  = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN    = 10;
    localparam int BLOCK_NIBS   = shapad_pkg::DEF_BLOCK_BITS / 4;
    localparam int OFFSET_NIBS  = shapad_pkg::DEF_LENGTH_OFF_BITS / 4;
    localparam int LEN_NIBS     = BLOCK_NIBS - OFFSET_NIBS;

    // valid_nibbles codes beyond the ones the package names
    localparam logic [1:0] VN_BYTE = 2'd2;
    localparam logic [1:0] VN_WIDE = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] nibs;
        logic       last;
    } msg_item_t;

    typedef struct packed {
        logic [shapad_pkg::WORD_BITS-1:0] word;
        logic                             block_end;
        logic                             message_end;
    } pad_word_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [15:0]                      s_tdata  = '0;   // data_byte[7:0], valid_nibbles[9:8]
    logic                             s_tlast  = 1'b0; // is_last
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [shapad_pkg::WORD_BITS-1:0] m_tdata;         // word[63:0]
    logic                             m_tuser;         // block_end
    logic                             m_tlast;         // message_end

    sha512_message_padder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    msg_item_t send_q[$];
    pad_word_t pending_words[$];

    // padder model state
    logic [shapad_pkg::WORD_BITS-1:0] open_word = '0;
    int                               open_pos  = 0;
    logic [63:0]                      nib_total = '0;

    int items_queued  = 0;
    int items_taken   = 0;
    int messages_done = 0;
    int words_seen    = 0;
    int blocks_seen   = 0;
    int mismatches    = 0;
    int cycles        = 0;

    msg_item_t next_item;
    pad_word_t want;
    int s_gap  = 0;
    int s_calm = 0;
    int m_hold = 0;
    int m_calm = 0;

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_nibble(input logic [3:0] nib, input logic closing);
        pad_word_t w;
        open_word = {open_word[shapad_pkg::WORD_BITS-5:0], nib};
        open_pos++;
        if (open_pos % shapad_pkg::WORD_NIBS == 0) begin
            w.word        = open_word;
            w.block_end   = (open_pos >= BLOCK_NIBS);
            w.message_end = closing;
            pending_words.insert(pending_words.size(), w);
            open_word = '0;
            if (w.block_end)
                open_pos = 0;
        end
    endtask

    task automatic pad_predict(input msg_item_t it);
        logic [1:0]   n;
        logic [127:0] bit_len;
        n = (it.nibs == VN_WIDE) ? VN_BYTE : it.nibs;
        if (n != shapad_pkg::VN_NONE) begin
            add_nibble(it.data[7:4], 1'b0);
            nib_total++;
        end
        if (n == VN_BYTE) begin
            add_nibble(it.data[3:0], 1'b0);
            nib_total++;
        end
        if (it.last) begin
            bit_len = {62'd0, nib_total, 2'b00};
            add_nibble(shapad_pkg::PAD_MARK, 1'b0);
            while (open_pos != OFFSET_NIBS)
                add_nibble(4'h0, 1'b0);
            // the final length nibble always closes a word
            for (int i = LEN_NIBS - 1; i >= 0; i--)
                add_nibble(bit_len[i*4 +: 4], i == 0);
            open_word = '0;
            open_pos  = 0;
            nib_total = '0;
            messages_done++;
        end
    endtask

    task automatic queue_item(input logic [7:0] data, input logic [1:0] nibs,
                              input logic last);
        msg_item_t it;
        it.data = data;
        it.nibs = nibs;
        it.last = last;
        send_q.insert(send_q.size(), it);
        if (nibs != shapad_pkg::VN_NONE || last)
            items_queued++;
    endtask

    task automatic queue_message(input int nbytes);
        logic [1:0] nibs;
        for (int k = 0; k < nbytes; k++) begin
            nibs = VN_BYTE;
            case ($urandom_range(0, 19))
                0: nibs = shapad_pkg::VN_HIGH;
                1: nibs = VN_WIDE;
                2: queue_item(8'($urandom), shapad_pkg::VN_NONE, 1'b0);
                default: ;
            endcase
            queue_item(8'($urandom), nibs, 1'b0);
        end
        queue_item(8'($urandom), 2'($urandom), 1'b1);
    endtask

    task automatic report_mismatch(input pad_word_t exp_w, input logic have);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            if (have)
                $display("mismatch at word %0d: expected %h/%b/%b, got %h/%b/%b",
                         words_seen, exp_w.word, exp_w.block_end, exp_w.message_end,
                         m_tdata, m_tuser, m_tlast);
            else
                $display("unexpected word %0d: got %h/%b/%b",
                         words_seen, m_tdata, m_tuser, m_tlast);
        end
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (send_q.size() > 0) begin
                next_item = send_q.pop_front();
                s_tdata  <= {6'd0, next_item.nibs, next_item.data};
                s_tlast  <= next_item.last;
                s_tvalid <= 1'b1;
                if (s_calm > 0)
                    s_calm = s_calm - 1;
                else if ($urandom_range(0, 63) == 0)
                    s_calm = $urandom_range(20, 60);
                else
                    s_gap = draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side: predict on input transfers, check on output transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                next_item.data = s_tdata[7:0];
                next_item.nibs = s_tdata[9:8];
                next_item.last = s_tlast;
                pad_predict(next_item);
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_words.size() == 0) begin
                    want = '0;
                    report_mismatch(want, 1'b0);
                end else begin
                    want = pending_words.pop_front();
                    if (m_tdata !== want.word || m_tuser !== want.block_end ||
                        m_tlast !== want.message_end)
                        report_mismatch(want, 1'b1);
                end
                words_seen++;
                if (m_tuser === 1'b1)
                    blocks_seen++;
            end
            if (m_hold > 0) begin
                m_hold = m_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_calm > 0)
                    m_calm = m_calm - 1;
                else if ($urandom_range(0, 63) == 0)
                    m_calm = $urandom_range(30, 80);
                else if ($urandom_range(0, 3) == 0)
                    m_hold = draw_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d words outstanding", pending_words.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int total;
        int r;

        // directed: empty message, byte extremes, odd nibble counts, idle items
        queue_item(8'h00, shapad_pkg::VN_NONE, 1'b1);
        queue_item(8'hFF, VN_BYTE, 1'b1);
        queue_item(8'h00, VN_BYTE, 1'b1);
        queue_item(8'hA5, shapad_pkg::VN_HIGH, 1'b1);
        queue_item(8'h5A, VN_WIDE, 1'b1);
        queue_item(8'h3C, shapad_pkg::VN_NONE, 1'b0);
        queue_item(8'h12, VN_BYTE, 1'b0);
        queue_item(8'h34, shapad_pkg::VN_HIGH, 1'b0);
        queue_item(8'hFF, VN_WIDE, 1'b0);
        queue_item(8'h80, VN_BYTE, 1'b1);
        // exactly one full word, then a last transfer carrying no nibbles
        for (int k = 1; k <= 8; k++)
            queue_item(8'(k * 17), VN_BYTE, 1'b0);
        queue_item(8'h00, shapad_pkg::VN_NONE, 1'b1);

        // random: mostly short messages, some near the length-field boundary
        while (items_queued < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                queue_message($urandom_range(0, 20));
            else if (r < 90)
                queue_message($urandom_range(108, 116) +
                              (($urandom_range(0, 3) == 0) ? 128 : 0));
            else
                queue_item(8'($urandom), 2'($urandom), 1'($urandom));
        end
        total = send_q.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_taken < total || pending_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("ran %0d messages over %0d input transfers in %0d cycles",
                 messages_done, items_taken, cycles);
        $display("checked %0d padded words, %0d of them closing a block; %0d mismatches",
                 words_seen, blocks_seen, mismatches);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
sv/shapad_pkg.sv
sv/shapad_ctrl.sv
sv/shapad_dp.sv
sv/sha512_message_padder_top.sv
verif/sha512_message_padder_top_test.sv
